### rtl/pkta_pkg.sv
// shared widths, register indexes and limits for the packed kv tile address block
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package pkta_pkg;

    localparam int MAX_BATCH    = 8;
    localparam int MAX_HEAD_DIM = 256;
    localparam int MAX_CAPACITY = 65536;
    localparam int MAX_HEADS    = 64;

    localparam int TILE_FP16 = 24;
    localparam int TILE_BF16 = 48;

    // field widths
    localparam int SEL_W   = 1;
    localparam int BATCH_W = 3;
    localparam int HEAD_W  = 6;
    localparam int POS_W   = 16;
    localparam int DIM_W   = 9;
    localparam int BITS_W  = 16;
    localparam int ADDR_W  = 34;

    // configuration registers
    localparam int FMT_W   = 1;
    localparam int HEADS_W = 7;
    localparam int HW_W    = 9;
    localparam int CAP_W   = 17;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_KV_FORMAT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KV_HEADS     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEAD_WIDTH   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEQ_CAPACITY = 2'd3;

    localparam logic [FMT_W-1:0]   RST_KV_FORMAT    = 1'd0;
    localparam logic [HEADS_W-1:0] RST_KV_HEADS     = 7'd1;
    localparam logic [HW_W-1:0]    RST_HEAD_WIDTH   = 9'd64;
    localparam logic [CAP_W-1:0]   RST_SEQ_CAPACITY = 17'd1024;

endpackage

`default_nettype wire

### rtl/pkta_in_if.sv
// element channel: valid/ready handshake with coordinates and raw element bits
// depends on pkta_pkg for field widths
`default_nettype none

interface pkta_in_if;
    logic                          valid;
    logic                          ready;
    logic [pkta_pkg::SEL_W-1:0]    tensor_sel;
    logic [pkta_pkg::BATCH_W-1:0]  batch_index;
    logic [pkta_pkg::HEAD_W-1:0]   head_index;
    logic [pkta_pkg::POS_W-1:0]    seq_pos;
    logic [pkta_pkg::DIM_W-1:0]    dim_index;
    logic [pkta_pkg::BITS_W-1:0]   element_bits;

    modport source (output valid, tensor_sel, batch_index, head_index, seq_pos,
                    dim_index, element_bits, input ready);
    modport sink   (input valid, tensor_sel, batch_index, head_index, seq_pos,
                    dim_index, element_bits, output ready);
endinterface

`default_nettype wire

### rtl/pkta_out_if.sv
// result channel: valid/ready handshake with destination address, data and status
// depends on pkta_pkg for field widths
`default_nettype none

interface pkta_out_if;
    logic                         valid;
    logic                         ready;
    logic [pkta_pkg::ADDR_W-1:0]  element_address;
    logic [pkta_pkg::BITS_W-1:0]  write_bits;
    logic                         status;

    modport source (output valid, element_address, write_bits, status, input ready);
    modport sink   (input valid, element_address, write_bits, status, output ready);
endinterface

`default_nettype wire

### rtl/packed_kv_tile_address.sv
// top level of the packed kv tile address generator: config registers and a
// four-stage address pipeline; depends on pkta_pkg, pkta_in_if and pkta_out_if
`default_nettype none

// Scatter address generator for a tiled key/value cache. Every element
// transfer on i_elem gives one registered result on o_addr: the
// element index in the packed cache, the data to store (zero in padding
// columns) and a status bit, 1 when the request is out of range or the
// configuration is invalid, in which case address and data are zero. The
// pipeline has four register stages (tile divide, intra-tile offset and
// tile product, block size and index, block base add); a new element is
// taken every cycle, and a held result only stops the stages behind it once
// they are full. The user writes configuration through i_cfg_we/i_cfg_index/
// i_cfg_data only while no element is in flight; the block itself does not enforce it.
module packed_kv_tile_address (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pkta_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [pkta_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pkta_in_if.sink                                i_elem,
    pkta_out_if.source                             o_addr
);

    localparam int AW = pkta_pkg::ADDR_W;

    // floor(x/3) for 16-bit x by reciprocal multiply
    function automatic logic [15:0] div3(input logic [15:0] x);
        logic [32:0] p;
        p = 33'(x) * 33'd43691;
        return p[32:17];
    endfunction

    // x times the tile width (24 or 48) by shift and add
    function automatic logic [AW-1:0] mul_t(input logic [AW-1:0] x, input logic fmt);
        logic [AW-1:0] x24;
        x24 = (x << 4) + (x << 3);
        return fmt ? (x24 << 1) : x24;
    endfunction

    // size that the tile quotient is multiplied by: padded width or sequence length
    function automatic logic [17:0] n2_sel_mb(input logic sel, input logic [9:0] hs,
                                              input logic [17:0] sl);
        return sel ? sl : 18'(hs);
    endfunction

    // configuration registers
    logic [pkta_pkg::FMT_W-1:0]   r_kv_format;
    logic [pkta_pkg::HEADS_W-1:0] r_kv_heads;
    logic [pkta_pkg::HW_W-1:0]    r_head_width;
    logic [pkta_pkg::CAP_W-1:0]   r_seq_capacity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kv_format    <= pkta_pkg::RST_KV_FORMAT;
            r_kv_heads     <= pkta_pkg::RST_KV_HEADS;
            r_head_width   <= pkta_pkg::RST_HEAD_WIDTH;
            r_seq_capacity <= pkta_pkg::RST_SEQ_CAPACITY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pkta_pkg::CFG_KV_FORMAT:    r_kv_format    <= i_cfg_data[pkta_pkg::FMT_W-1:0];
                pkta_pkg::CFG_KV_HEADS:     r_kv_heads     <= i_cfg_data[pkta_pkg::HEADS_W-1:0];
                pkta_pkg::CFG_HEAD_WIDTH:   r_head_width   <= i_cfg_data[pkta_pkg::HW_W-1:0];
                pkta_pkg::CFG_SEQ_CAPACITY: r_seq_capacity <= i_cfg_data[pkta_pkg::CAP_W-1:0];
                default: ;
            endcase
        end
    end

    logic fmt;
    assign fmt = r_kv_format[0];

    // stage enables: a stage moves when empty or when the one after it moves
    logic r1_valid, r2_valid, r3_valid, r4_valid;
    logic en1, en2, en3, en4;

    assign en4 = !r4_valid || o_addr.ready;
    assign en3 = !r3_valid || en4;
    assign en2 = !r2_valid || en3;
    assign en1 = !r1_valid || en2;
    assign i_elem.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (en1) r1_valid <= i_elem.valid;
            if (en2) r2_valid <= r1_valid;
            if (en3) r3_valid <= r2_valid;
            if (en4) r4_valid <= r3_valid;
        end
    end

    // ---------------- stage 1: tile quotients and range checks
    logic        r1_sel;
    logic [2:0]  r1_b;
    logic [5:0]  r1_h;
    logic [15:0] r1_pos;
    logic [8:0]  r1_d;
    logic [15:0] r1_bits;
    logic [11:0] r1_q_pos;
    logic [4:0]  r1_q_d;
    logic [4:0]  r1_q_hw;
    logic [12:0] r1_q_cap;
    logic        r1_bad;

    logic [9:0]  n1_hw_t;
    logic [17:0] n1_cap_t;
    logic [15:0] n1_q_pos, n1_q_d, n1_q_hw, n1_q_cap;
    logic        n1_bad;

    always_comb begin
        // add tile width minus one before dividing to round up
        n1_hw_t  = 10'(r_head_width) +
                   (fmt ? 10'(pkta_pkg::TILE_BF16 - 1) : 10'(pkta_pkg::TILE_FP16 - 1));
        n1_cap_t = 18'(r_seq_capacity) +
                   (fmt ? 18'(pkta_pkg::TILE_BF16 - 1) : 18'(pkta_pkg::TILE_FP16 - 1));
        // divide by 8 or 16, then by 3
        n1_q_pos = div3(fmt ? 16'(i_elem.seq_pos >> 4) : 16'(i_elem.seq_pos >> 3));
        n1_q_d   = div3(fmt ? 16'(i_elem.dim_index >> 4) : 16'(i_elem.dim_index >> 3));
        n1_q_hw  = div3(fmt ? 16'(n1_hw_t >> 4) : 16'(n1_hw_t >> 3));
        n1_q_cap = div3(fmt ? 16'(n1_cap_t >> 4) : 16'(n1_cap_t >> 3));

        n1_bad = 1'b0;
        if (r_kv_heads == '0 || 32'(r_kv_heads) > pkta_pkg::MAX_HEADS) n1_bad = 1'b1;
        if (r_head_width == '0 || 32'(r_head_width) > pkta_pkg::MAX_HEAD_DIM) n1_bad = 1'b1;
        if (r_seq_capacity == '0 || 32'(r_seq_capacity) > pkta_pkg::MAX_CAPACITY)
            n1_bad = 1'b1;
        if (17'(i_elem.seq_pos) >= r_seq_capacity) n1_bad = 1'b1;
        if (7'(i_elem.head_index) >= r_kv_heads) n1_bad = 1'b1;
        if (32'(i_elem.batch_index) >= pkta_pkg::MAX_BATCH) n1_bad = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_sel   <= i_elem.tensor_sel[0];
            r1_b     <= i_elem.batch_index;
            r1_h     <= i_elem.head_index;
            r1_pos   <= i_elem.seq_pos;
            r1_d     <= i_elem.dim_index;
            r1_bits  <= i_elem.element_bits;
            r1_q_pos <= n1_q_pos[11:0];
            r1_q_d   <= n1_q_d[4:0];
            r1_q_hw  <= n1_q_hw[4:0];
            r1_q_cap <= n1_q_cap[12:0];
            r1_bad   <= n1_bad;
        end
    end

    // ---------------- stage 2: padded sizes, intra-tile offset, tile product
    logic [2:0]  r2_b;
    logic [5:0]  r2_h;
    logic [15:0] r2_bits;
    logic [9:0]  r2_hs;
    logic [17:0] r2_sl;
    logic [30:0] r2_term;
    logic [21:0] r2_rest;
    logic        r2_bad;
    logic        r2_pad;

    logic [9:0]  n2_hw_pt, n2_hw_pr, n2_hs;
    logic [17:0] n2_cap_pt, n2_cap_pr, n2_sl;
    logic [15:0] n2_rem_pos;
    logic [8:0]  n2_rem_d;
    logic [12:0] n2_qa;
    logic [AW-1:0] n2_hi;
    logic [21:0] n2_rest;
    logic [30:0] n2_term;

    always_comb begin
        n2_hw_pt  = 10'(mul_t(AW'(r1_q_hw), fmt));
        n2_cap_pt = 18'(mul_t(AW'(r1_q_cap), fmt));
        n2_hw_pr  = fmt ? ((10'(r_head_width) + 10'd1) & ~10'd1) : 10'(r_head_width);
        n2_cap_pr = fmt ? ((18'(r_seq_capacity) + 18'd1) & ~18'd1) : 18'(r_seq_capacity);
        n2_rem_pos = r1_pos - 16'(mul_t(AW'(r1_q_pos), fmt));
        n2_rem_d   = r1_d - 9'(mul_t(AW'(r1_q_d), fmt));

        if (!r1_sel) begin
            // key: tiles over the sequence, pack over dim
            n2_hs = n2_hw_pr;
            n2_sl = n2_cap_pt;
            n2_qa = 13'(r1_q_pos);
            n2_hi = mul_t(AW'(fmt ? (r1_d >> 1) : r1_d), fmt);
            n2_hi = fmt ? (n2_hi << 1) : n2_hi;
            n2_rest = 22'(n2_hi) +
                      (fmt ? 22'({n2_rem_pos[5:0], r1_d[0]}) : 22'(n2_rem_pos[5:0]));
        end else begin
            // value: tiles over dim, pack over the sequence
            n2_hs = n2_hw_pt;
            n2_sl = n2_cap_pr;
            n2_qa = 13'(r1_q_d);
            n2_hi = mul_t(AW'(fmt ? (r1_pos >> 1) : r1_pos), fmt);
            n2_hi = fmt ? (n2_hi << 1) : n2_hi;
            n2_rest = 22'(n2_hi) +
                      (fmt ? 22'({n2_rem_d[5:0], r1_pos[0]}) : 22'(n2_rem_d[5:0]));
        end
        n2_term = 31'(n2_qa) * 31'(n2_sel_mb(r1_sel, n2_hs, n2_sl));
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_b    <= r1_b;
            r2_h    <= r1_h;
            r2_bits <= r1_bits;
            r2_hs   <= n2_hs;
            r2_sl   <= n2_sl;
            r2_term <= n2_term;
            r2_rest <= n2_rest;
            r2_bad  <= r1_bad || (10'(r1_d) >= n2_hs);
            r2_pad  <= (r1_d >= r_head_width);
        end
    end

    // ---------------- stage 3: block size, pair number, intra-block index
    logic [27:0]   r3_elems;
    logic [9:0]    r3_pair;
    logic [AW-1:0] r3_idx;
    logic [15:0]   r3_bits;
    logic          r3_bad;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_elems <= 28'(r2_sl) * 28'(r2_hs);
            r3_pair  <= 10'(r2_b) * 10'(r_kv_heads) + 10'(r2_h);
            r3_idx   <= mul_t(AW'(r2_term), fmt) + AW'(r2_rest);
            r3_bits  <= r2_pad ? '0 : r2_bits;
            r3_bad   <= r2_bad;
        end
    end

    // ---------------- stage 4: block base plus index, output register
    logic [AW-1:0] r4_addr;
    logic [15:0]   r4_bits;
    logic          r4_status;
    logic [37:0]   n4_base;

    assign n4_base = 38'(r3_pair) * 38'(r3_elems);

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_addr   <= r3_bad ? '0 : (n4_base[AW-1:0] + r3_idx);
            r4_bits   <= r3_bad ? '0 : r3_bits;
            r4_status <= r3_bad;
        end
    end

    assign o_addr.valid           = r4_valid;
    assign o_addr.element_address = r4_addr;
    assign o_addr.write_bits      = r4_bits;
    assign o_addr.status          = r4_status;

endmodule

`default_nettype wire

### sim/pkta_tb_pkg.sv
// code names shared by the testbench top and the address checker
// depends on nothing; compiled after pkta_pkg and before the other sim files
`default_nettype none

package pkta_tb_pkg;

    localparam logic SEL_KEY   = 1'b0;
    localparam logic SEL_VALUE = 1'b1;

    localparam logic FMT_FP16 = 1'b0;
    localparam logic FMT_BF16 = 1'b1;

    localparam int PACK_FP16 = 1;
    localparam int PACK_BF16 = 2;

    localparam logic STATUS_WRITE = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

endpackage

`default_nettype wire

### sim/pkta_address_checker.sv
// watches the element and result channels and the register port, predicts the
// scatter address of every element and compares it with the block's result
// depends on pkta_pkg, pkta_tb_pkg, pkta_in_if and pkta_out_if
`default_nettype none

module pkta_address_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pkta_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [pkta_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pkta_in_if                                     elem_mon,
    pkta_out_if                                    addr_mon,
    output int                                     o_outstanding,
    output int                                     o_failures
);

    typedef struct packed {
        logic [pkta_pkg::ADDR_W-1:0] address;
        logic [pkta_pkg::BITS_W-1:0] bits;
        logic                        status;
    } t_cache_write;

    logic [pkta_pkg::FMT_W-1:0]   fmt_q;
    logic [pkta_pkg::HEADS_W-1:0] heads_q;
    logic [pkta_pkg::HW_W-1:0]    width_q;
    logic [pkta_pkg::CAP_W-1:0]   cap_q;

    t_cache_write pending_writes[$];
    int           mismatches = 0;

    function automatic longint unsigned pad_to(longint unsigned v, longint unsigned p);
        return ((v + p - 1) / p) * p;
    endfunction

    function automatic t_cache_write predict_write(
        logic [pkta_pkg::SEL_W-1:0] sel, logic [pkta_pkg::BATCH_W-1:0] batch,
        logic [pkta_pkg::HEAD_W-1:0] head, logic [pkta_pkg::POS_W-1:0] pos,
        logic [pkta_pkg::DIM_W-1:0] dim, logic [pkta_pkg::BITS_W-1:0] bits);
        longint unsigned tile, pack, nheads, hw, cap, b, h, p, d, hs, sl, idx;
        bit              out_of_range;
        t_cache_write    w;
        tile   = (fmt_q == pkta_tb_pkg::FMT_BF16) ? pkta_pkg::TILE_BF16 : pkta_pkg::TILE_FP16;
        pack   = (fmt_q == pkta_tb_pkg::FMT_BF16) ? pkta_tb_pkg::PACK_BF16
                                                  : pkta_tb_pkg::PACK_FP16;
        nheads = heads_q;
        hw     = width_q;
        cap    = cap_q;
        b      = batch;
        h      = head;
        p      = pos;
        d      = dim;
        out_of_range = nheads == 0 || nheads > pkta_pkg::MAX_HEADS || hw == 0 ||
                       hw > pkta_pkg::MAX_HEAD_DIM || cap == 0 ||
                       cap > pkta_pkg::MAX_CAPACITY || p >= cap || h >= nheads ||
                       b >= pkta_pkg::MAX_BATCH;
        if (sel == pkta_tb_pkg::SEL_KEY) begin
            // tiles run along the sequence, dims packed in a row (in pairs for bf16)
            hs  = pad_to(hw, pack);
            sl  = pad_to(cap, tile);
            idx = (p / tile) * hs * tile + (d / pack) * tile * pack + (p % tile) * pack
                  + d % pack;
        end else begin
            // tiles run along the dims, positions packed in a row (in pairs for bf16)
            hs  = pad_to(hw, tile);
            sl  = pad_to(cap, pack);
            idx = (d / tile) * sl * tile + (p / pack) * tile * pack + (d % tile) * pack
                  + p % pack;
        end
        if (d >= hs) out_of_range = 1'b1;
        if (out_of_range) begin
            w.address = '0;
            w.bits    = '0;
            w.status  = pkta_tb_pkg::STATUS_RANGE;
        end else begin
            w.address = pkta_pkg::ADDR_W'((b * nheads + h) * sl * hs + idx);
            w.bits    = (d < hw) ? bits : '0;
            w.status  = pkta_tb_pkg::STATUS_WRITE;
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_cache_write want;
        if (!i_rst_n) begin
            fmt_q   <= pkta_pkg::RST_KV_FORMAT;
            heads_q <= pkta_pkg::RST_KV_HEADS;
            width_q <= pkta_pkg::RST_HEAD_WIDTH;
            cap_q   <= pkta_pkg::RST_SEQ_CAPACITY;
            pending_writes.delete();
            o_outstanding <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pkta_pkg::CFG_KV_FORMAT:    fmt_q   <= i_cfg_data[pkta_pkg::FMT_W-1:0];
                    pkta_pkg::CFG_KV_HEADS:     heads_q <= i_cfg_data[pkta_pkg::HEADS_W-1:0];
                    pkta_pkg::CFG_HEAD_WIDTH:   width_q <= i_cfg_data[pkta_pkg::HW_W-1:0];
                    pkta_pkg::CFG_SEQ_CAPACITY: cap_q   <= i_cfg_data[pkta_pkg::CAP_W-1:0];
                    default: ;
                endcase
            end
            if (addr_mon.valid && addr_mon.ready) begin
                if (pending_writes.size() == 0) begin
                    $display("%0t: result transfer with nothing expected: addr %h bits %h st %b",
                             $time, addr_mon.element_address, addr_mon.write_bits,
                             addr_mon.status);
                    mismatches++;
                end else begin
                    want = pending_writes.pop_front();
                    if (addr_mon.element_address !== want.address) begin
                        $display("%0t: element_address expected %h got %h",
                                 $time, want.address, addr_mon.element_address);
                        mismatches++;
                    end
                    if (addr_mon.write_bits !== want.bits) begin
                        $display("%0t: write_bits expected %h got %h",
                                 $time, want.bits, addr_mon.write_bits);
                        mismatches++;
                    end
                    if (addr_mon.status !== want.status) begin
                        $display("%0t: status expected %b got %b",
                                 $time, want.status, addr_mon.status);
                        mismatches++;
                    end
                end
            end
            if (elem_mon.valid && elem_mon.ready)
                pending_writes.push_back(predict_write(elem_mon.tensor_sel,
                    elem_mon.batch_index, elem_mon.head_index, elem_mon.seq_pos,
                    elem_mon.dim_index, elem_mon.element_bits));
            o_outstanding <= pending_writes.size();
        end
        o_failures <= mismatches;
    end

endmodule

`default_nettype wire

### sim/tb.sv
// top of the packed kv tile address testbench: clock, reset, register set-up,
// element stimulus with random gaps and result back-pressure, and the verdict;
// depends on pkta_pkg, pkta_tb_pkg, the channel interfaces and pkta_address_checker
`default_nettype none

module tb;

    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 13;
    localparam longint TIMEOUT  = 64'd8_000_000;

    typedef struct {
        logic fmt;
        int   heads;
        int   hw;
        int   cap;
        int   count;
    } t_kv_setting;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [pkta_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [pkta_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    int                               outstanding;
    int                               failures;
    int                               tx_calm = 0;
    int                               rx_calm = 0;

    pkta_in_if  elem_ch ();
    pkta_out_if addr_ch ();

    packed_kv_tile_address dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_elem      (elem_ch),
        .o_addr      (addr_ch)
    );

    pkta_address_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .elem_mon      (elem_ch),
        .addr_mon      (addr_ch),
        .o_outstanding (outstanding),
        .o_failures    (failures)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // idle length per transfer, with the odd stretch of back-to-back traffic
    function automatic int draw_idle(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) calm = $urandom_range(8, 40);
        return $urandom_range(0, 18);
    endfunction

    // called at a clock edge; returns at the edge where the element transfers
    task automatic send_element(input logic [pkta_pkg::SEL_W-1:0] sel,
                                input logic [pkta_pkg::BATCH_W-1:0] b,
                                input logic [pkta_pkg::HEAD_W-1:0] h,
                                input logic [pkta_pkg::POS_W-1:0] pos,
                                input logic [pkta_pkg::DIM_W-1:0] d,
                                input logic [pkta_pkg::BITS_W-1:0] bits);
        int gap;
        gap = draw_idle(tx_calm);
        if (gap > 0) begin
            elem_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        elem_ch.valid        <= 1'b1;
        elem_ch.tensor_sel   <= sel;
        elem_ch.batch_index  <= b;
        elem_ch.head_index   <= h;
        elem_ch.seq_pos      <= pos;
        elem_ch.dim_index    <= d;
        elem_ch.element_bits <= bits;
        do @(posedge i_clk); while (!(elem_ch.valid && elem_ch.ready));
    endtask

    task automatic send_random_element(input t_kv_setting s);
        logic [pkta_pkg::SEL_W-1:0]   sel;
        logic [pkta_pkg::BATCH_W-1:0] b;
        logic [pkta_pkg::HEAD_W-1:0]  h;
        logic [pkta_pkg::POS_W-1:0]   pos;
        logic [pkta_pkg::DIM_W-1:0]   d;
        int                           roll, tile, pack, width, lim;
        bit                           usable;
        usable = s.heads >= 1 && s.heads <= pkta_pkg::MAX_HEADS && s.hw >= 1 &&
                 s.hw <= pkta_pkg::MAX_HEAD_DIM && s.cap >= 1 &&
                 s.cap <= pkta_pkg::MAX_CAPACITY;
        sel   = pkta_pkg::SEL_W'($urandom_range(0, 1));
        b     = pkta_pkg::BATCH_W'($urandom_range(0, pkta_pkg::MAX_BATCH - 1));
        h     = pkta_pkg::HEAD_W'($urandom);
        pos   = pkta_pkg::POS_W'($urandom);
        d     = pkta_pkg::DIM_W'($urandom);
        tile  = (s.fmt == pkta_tb_pkg::FMT_BF16) ? pkta_pkg::TILE_BF16 : pkta_pkg::TILE_FP16;
        pack  = (s.fmt == pkta_tb_pkg::FMT_BF16) ? pkta_tb_pkg::PACK_BF16
                                                 : pkta_tb_pkg::PACK_FP16;
        width = (sel == pkta_tb_pkg::SEL_KEY) ? ((s.hw + pack - 1) / pack) * pack
                                              : ((s.hw + tile - 1) / tile) * tile;
        roll  = $urandom_range(0, 99);
        if (usable && roll < 92) begin
            h = pkta_pkg::HEAD_W'($urandom_range(0, s.heads - 1));
            case ($urandom_range(0, 7))
                0:       pos = '0;
                1:       pos = pkta_pkg::POS_W'(s.cap - 1);
                default: pos = pkta_pkg::POS_W'($urandom_range(0, s.cap - 1));
            endcase
            case ($urandom_range(0, 7))
                0:       d = pkta_pkg::DIM_W'(width - 1);
                1:       d = pkta_pkg::DIM_W'(s.hw - 1);
                default: d = pkta_pkg::DIM_W'($urandom_range(0, width - 1));
            endcase
            // a few requests at or past one of the limits (head, position or dim)
            if (roll >= 80) begin
                case ($urandom_range(0, 2))
                    0: begin
                        if (s.heads < pkta_pkg::MAX_HEADS)
                            h = pkta_pkg::HEAD_W'($urandom_range(s.heads,
                                                                 pkta_pkg::MAX_HEADS - 1));
                    end
                    1: begin
                        lim = s.cap + $urandom_range(0, 3);
                        pos = (lim > 65535) ? '1 : pkta_pkg::POS_W'(lim);
                    end
                    default: begin
                        lim = width + $urandom_range(0, 3);
                        d   = (lim > 511) ? '1 : pkta_pkg::DIM_W'(lim);
                    end
                endcase
            end
        end
        send_element(sel, b, h, pos, d, pkta_pkg::BITS_W'($urandom_range(0, 16'hFFFF)));
    endtask

    task automatic wait_drain();
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [pkta_pkg::CFG_INDEX_W-1:0] idx, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= pkta_pkg::CFG_DATA_W'(value);
        @(posedge i_clk);
    endtask

    // result side back-pressure
    initial begin
        int stall;
        addr_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_idle(rx_calm);
            if (stall > 0) begin
                addr_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            addr_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(addr_ch.valid && addr_ch.ready));
        end
    end

    initial begin
        t_kv_setting s;
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_index          <= pkta_pkg::CFG_KV_FORMAT;
        i_cfg_data           <= '0;
        elem_ch.valid        <= 1'b0;
        elem_ch.tensor_sel   <= '0;
        elem_ch.batch_index  <= '0;
        elem_ch.head_index   <= '0;
        elem_ch.seq_pos      <= '0;
        elem_ch.dim_index    <= '0;
        elem_ch.element_bits <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: fp16, one head, width 64, capacity 1024
        send_element(pkta_tb_pkg::SEL_KEY,   3'd0, 6'd0,  16'd0,     9'd0,   16'h0000);
        send_element(pkta_tb_pkg::SEL_KEY,   3'd7, 6'd0,  16'd1023,  9'd63,  16'hFFFF);
        // padding column
        send_element(pkta_tb_pkg::SEL_VALUE, 3'd7, 6'd0,  16'd1023,  9'd71,  16'hFFFF);
        // first padding column
        send_element(pkta_tb_pkg::SEL_VALUE, 3'd0, 6'd0,  16'd5,     9'd64,  16'hA5A5);
        // past padded width
        send_element(pkta_tb_pkg::SEL_VALUE, 3'd0, 6'd0,  16'd5,     9'd72,  16'h1234);
        // key has no padding here
        send_element(pkta_tb_pkg::SEL_KEY,   3'd1, 6'd0,  16'd5,     9'd64,  16'h1234);
        // at capacity
        send_element(pkta_tb_pkg::SEL_KEY,   3'd2, 6'd0,  16'd1024,  9'd3,   16'h1234);
        // head out of range
        send_element(pkta_tb_pkg::SEL_KEY,   3'd3, 6'd1,  16'd10,    9'd3,   16'h1234);
        send_element(pkta_tb_pkg::SEL_VALUE, 3'd7, 6'd63, 16'd65535, 9'd511, 16'hFFFF);
        // last row of a tile, then first row of the next
        send_element(pkta_tb_pkg::SEL_KEY,   3'd4, 6'd0,  16'd23,    9'd5,   16'h8000);
        send_element(pkta_tb_pkg::SEL_KEY,   3'd4, 6'd0,  16'd24,    9'd5,   16'h0001);
        send_element(pkta_tb_pkg::SEL_VALUE, 3'd5, 6'd0,  16'd1,     9'd23,  16'h7FFF);
        send_element(pkta_tb_pkg::SEL_VALUE, 3'd5, 6'd0,  16'd2,     9'd24,  16'hFFFE);
        send_element(pkta_tb_pkg::SEL_VALUE, 3'd6, 6'd0,  16'd1022,  9'd63,  16'h5555);
        send_element(pkta_tb_pkg::SEL_KEY,   3'd6, 6'd0,  16'd512,   9'd0,   16'hAAAA);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:  s = '{pkta_tb_pkg::FMT_FP16, 1, 64, 1024, 60};
                1:  s = '{pkta_tb_pkg::FMT_BF16, 64, 256, 65536, 110};
                2:  s = '{pkta_tb_pkg::FMT_FP16, 64, 256, 65536, 110};
                3:  s = '{pkta_tb_pkg::FMT_BF16, 1, 1, 1, 110};
                4:  s = '{pkta_tb_pkg::FMT_FP16, 1, 1, 1, 110};
                5:  s = '{pkta_tb_pkg::FMT_BF16, 37, 101, 1000, 110};
                6:  s = '{pkta_tb_pkg::FMT_FP16, 5, 23, 47, 110};
                7:  s = '{pkta_tb_pkg::FMT_BF16, 3, 47, 95, 110};
                // broken settings: every request must come back as out of range
                10: s = '{pkta_tb_pkg::FMT_FP16, 0, 0, 0, 40};
                11: s = '{pkta_tb_pkg::FMT_BF16, 127, 511, 131071, 40};
                default: s = '{logic'($urandom_range(0, 1)), $urandom_range(1, 64),
                               $urandom_range(1, 256), $urandom_range(1, 4096), 110};
            endcase
            if (phase != 0) begin
                elem_ch.valid <= 1'b0;
                wait_drain();
                write_reg(pkta_pkg::CFG_KV_FORMAT, int'(s.fmt));
                write_reg(pkta_pkg::CFG_KV_HEADS, s.heads);
                write_reg(pkta_pkg::CFG_HEAD_WIDTH, s.hw);
                write_reg(pkta_pkg::CFG_SEQ_CAPACITY, s.cap);
                i_cfg_we <= 1'b0;
            end
            repeat (s.count) send_random_element(s);
        end

        elem_ch.valid <= 1'b0;
        wait_drain();
        if (failures == 0)
            $display("packed_kv_tile_address regression: pass");
        else
            $display("packed_kv_tile_address regression: fail");
        $finish;
    end

    initial begin
        #(TIMEOUT);
        $display("packed_kv_tile_address regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
